// ===== rtl/smr_alu_pkg.sv =====
// Shared types and constants for the sign-magnitude rational ALU.
package smr_alu_pkg;
  localparam int W = 32;
  typedef logic [W-1:0] word_t;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_SIMP = 2'd2;
  localparam logic [1:0] OP_CMP = 2'd3;

  typedef struct packed {
    logic  start;
    word_t n;
    word_t d;
  } div_req_t;

  typedef struct packed {
    logic  done;
    logic  dz;
    word_t q;
    word_t r;
  } div_rsp_t;
endpackage

// ===== rtl/smr_alu_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module smr_alu_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  smr_alu_pkg::div_req_t req,
  output smr_alu_pkg::div_rsp_t rsp
);
  import smr_alu_pkg::*;

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  word_t       q_r, q_nxt, d_r, d_nxt;
  logic [W:0]  rem_r, rem_nxt;
  logic        done_r, done_nxt;
  logic        dz_r, dz_nxt;
  logic [W:0]  sh;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    dz_nxt   = dz_r;
    sh       = {rem_r[W-1:0], q_r[W-1]};
    if (req.start) begin
      d_nxt   = req.d;
      q_nxt   = req.n;
      rem_nxt = '0;
      cnt_nxt = 6'(W);
      dz_nxt  = (req.d == '0);
      if (req.d == '0) begin
        q_nxt    = '0;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = sh - {1'b0, d_r};
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    dz_r  <= dz_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.dz   = dz_r;
  assign rsp.q    = q_r;
  assign rsp.r    = rem_r[W-1:0];
endmodule

// ===== rtl/sign_magnitude_rational_alu_unit.sv =====
// Top level: sequencer around one shared divider and one multiplier.
// Compare does not use the divider. The other ops are data dependent: each
// Euclid step is one division, so long gcd chains make an item take longer.
// Throughput: one request at a time; in_tready is high only when idle.
// Reset is synchronous, active low, and clears the sequencer and out_tvalid.
module sign_magnitude_rational_alu_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[1:0], a_sign[2], a_num[34:3], a_den[66:35], b_sign[67],
  // b_num[99:68], b_den[131:100], zero fill to 136
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // res_sign[0], res_num[32:1], res_den[64:33], equal[65], div_zero[66], fill
  output logic [71:0]  out_tdata
);
  import smr_alu_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0, S_G = 5'd1, S_GW = 5'd2, S_RN = 5'd3,
    S_RNW = 5'd4, S_RD = 5'd5, S_RDW = 5'd6, S_NEXT = 5'd7, S_LG = 5'd8,
    S_L1 = 5'd9, S_L1W = 5'd10, S_MA = 5'd11, S_MAW = 5'd12, S_MB = 5'd13,
    S_MBW = 5'd14, S_X1 = 5'd15, S_X2 = 5'd16, S_X3 = 5'd17, S_SUM = 5'd18,
    S_OUT = 5'd19, S_MP = 5'd20, S_MP2 = 5'd21, S_CMP = 5'd22, S_CMP2 = 5'd23,
    S_LGW = 5'd24, S_MP3 = 5'd25, S_CMP3 = 5'd26;

  logic [4:0] st_r, st_nxt;
  logic [1:0] op_r, op_nxt;
  logic [1:0] step_r, step_nxt;
  logic       as_r, as_nxt, bs_r, bs_nxt;
  word_t an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  word_t x_r, x_nxt, y_r, y_nxt, g_r, g_nxt;
  word_t t_r, t_nxt, ma_r, ma_nxt, mb_r, mb_nxt;
  logic  dz_r, dz_nxt;
  logic  ov_r, ov_nxt;
  logic [71:0] od_r, od_nxt;
  word_t mx, my, prod_r;
  word_t cn, cd, pos, neg, dif, sn;
  logic  cs, osg;
  div_req_t dreq;
  div_rsp_t drsp;

  smr_alu_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  always_comb begin
    cs = step_r[0] ? bs_r : as_r;
    cn = step_r[0] ? bn_r : an_r;
    cd = step_r[0] ? bd_r : ad_r;
  end

  always_comb begin
    mx = an_r;
    my = ma_r;
    case (st_r)
      S_X1: begin mx = an_r; my = ma_r; end
      S_X2: begin mx = ad_r; my = ma_r; end
      S_X3: begin mx = bn_r; my = mb_r; end
      S_LG, S_LGW: begin mx = ad_r; my = bd_r; end
      S_MP: begin mx = an_r; my = bn_r; end
      S_MP2: begin mx = ad_r; my = bd_r; end
      S_CMP: begin mx = an_r; my = bd_r; end
      S_CMP2, S_CMP3: begin mx = ad_r; my = bn_r; end
      default: begin mx = an_r; my = ma_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mx * my;
  end

  always_comb begin
    pos = as_r ? bn_r : an_r;
    neg = as_r ? an_r : bn_r;
    dif = pos - neg;
    if (as_r == bs_r) begin
      sn  = an_r + bn_r;
      osg = as_r;
    end else if (dif > pos) begin
      sn  = ~dif + 1'b1;
      osg = 1'b1;
    end else begin
      sn  = dif;
      osg = 1'b0;
    end
  end

  always_comb begin
    st_nxt = st_r; op_nxt = op_r; step_nxt = step_r;
    as_nxt = as_r; bs_nxt = bs_r;
    an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    x_nxt = x_r; y_nxt = y_r; g_nxt = g_r; t_nxt = t_r;
    ma_nxt = ma_r; mb_nxt = mb_r; dz_nxt = dz_r;
    ov_nxt = ov_r; od_nxt = od_r;
    dreq.start = 1'b0; dreq.n = x_r; dreq.d = y_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt = in_tdata[1:0];
          as_nxt = in_tdata[2];
          an_nxt = in_tdata[34:3];
          ad_nxt = in_tdata[66:35];
          bs_nxt = in_tdata[67];
          bn_nxt = in_tdata[99:68];
          bd_nxt = in_tdata[131:100];
          dz_nxt = 1'b0;
          step_nxt = 2'd0;
          x_nxt = in_tdata[34:3];
          y_nxt = in_tdata[66:35];
          st_nxt = (in_tdata[1:0] == OP_CMP) ? S_CMP : S_G;
        end
      end
      S_G: begin
        if (y_r == '0) begin
          g_nxt = x_r;
          st_nxt = S_RN;
        end else if (y_r > x_r) begin
          x_nxt = y_r; y_nxt = x_r;
        end else begin
          dreq.start = 1'b1; dreq.n = x_r; dreq.d = y_r;
          st_nxt = S_GW;
        end
      end
      S_GW: if (drsp.done) begin
        x_nxt = y_r; y_nxt = drsp.r; st_nxt = S_G;
      end
      S_RN: begin
        dreq.start = 1'b1; dreq.n = cn; dreq.d = g_r; st_nxt = S_RNW;
      end
      S_RNW: if (drsp.done) begin
        dz_nxt = dz_r | drsp.dz; t_nxt = drsp.q; st_nxt = S_RD;
      end
      S_RD: begin
        dreq.start = 1'b1; dreq.n = cd; dreq.d = g_r; st_nxt = S_RDW;
      end
      S_RDW: if (drsp.done) begin
        dz_nxt = dz_r | drsp.dz;
        if (step_r[0]) begin bn_nxt = t_r; bd_nxt = drsp.q; end
        else begin an_nxt = t_r; ad_nxt = drsp.q; end
        st_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (step_r == 2'd2 || op_r == OP_SIMP) begin
          st_nxt = S_OUT;
        end else if (step_r == 2'd0) begin
          step_nxt = 2'd1; x_nxt = bn_r; y_nxt = bd_r; st_nxt = S_G;
        end else if (op_r == OP_MUL) begin
          st_nxt = S_MP;
        end else begin
          x_nxt = ad_r; y_nxt = bd_r; step_nxt = 2'd3; st_nxt = S_LG;
        end
      end
      S_LG: begin
        if (y_r == '0) begin
          g_nxt = x_r; st_nxt = S_LGW;
        end else if (y_r > x_r) begin
          x_nxt = y_r; y_nxt = x_r;
        end else begin
          dreq.start = 1'b1; dreq.n = x_r; dreq.d = y_r; st_nxt = S_L1W;
        end
      end
      S_L1W: if (drsp.done) begin
        x_nxt = y_r; y_nxt = drsp.r; st_nxt = S_LG;
      end
      S_LGW: st_nxt = S_L1;
      S_L1: begin
        dreq.start = 1'b1; dreq.n = prod_r; dreq.d = g_r; st_nxt = S_MA;
      end
      S_MA: if (drsp.done) begin
        dz_nxt = dz_r | drsp.dz; t_nxt = drsp.q;
        dreq.start = 1'b1; dreq.n = drsp.q; dreq.d = ad_r; st_nxt = S_MAW;
      end
      S_MAW: if (drsp.done) begin
        dz_nxt = dz_r | drsp.dz; ma_nxt = drsp.q;
        dreq.start = 1'b1; dreq.n = t_r; dreq.d = bd_r; st_nxt = S_MBW;
      end
      S_MBW: if (drsp.done) begin
        dz_nxt = dz_r | drsp.dz; mb_nxt = drsp.q; st_nxt = S_X1;
      end
      S_X1: st_nxt = S_X2;
      S_X2: begin an_nxt = prod_r; st_nxt = S_X3; end
      S_X3: begin ad_nxt = prod_r; st_nxt = S_MB; end
      S_MB: begin bn_nxt = prod_r; st_nxt = S_SUM; end
      S_SUM: begin
        as_nxt = osg; an_nxt = sn; st_nxt = S_OUT;
      end
      S_MP: st_nxt = S_MP2;
      S_MP2: begin
        an_nxt = prod_r;
        as_nxt = as_r ^ bs_r;
        st_nxt = S_MP3;
      end
      S_MP3: begin
        ad_nxt = prod_r; x_nxt = an_r; y_nxt = prod_r;
        step_nxt = 2'd2; st_nxt = S_G;
      end
      S_CMP: st_nxt = S_CMP2;
      S_CMP2: begin t_nxt = prod_r; st_nxt = S_CMP3; end
      S_CMP3: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {5'd0, 1'b0, t_r == prod_r, 65'd0};
          st_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {5'd0, dz_r, 1'b0, ad_r, an_r, as_r};
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    op_r <= op_nxt; step_r <= step_nxt; as_r <= as_nxt; bs_r <= bs_nxt;
    an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt; bd_r <= bd_nxt;
    x_r <= x_nxt; y_r <= y_nxt; g_r <= g_nxt; t_r <= t_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; dz_r <= dz_nxt; od_r <= od_nxt;
  end
endmodule

// ===== tb/tb.sv =====
// Testbench for the sign-magnitude rational ALU with an in-bench predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smr_alu_pkg::*;

  typedef struct {
    logic       sgn;
    logic [31:0] num;
    logic [31:0] den;
  } rat_t;

  typedef struct packed {
    logic        sgn;
    logic [31:0] num;
    logic [31:0] den;
    logic        eq;
    logic        dz;
  } alu_res_t;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [71:0]  out_tdata;

  alu_res_t  pending_q[$];
  int        errors = 0;
  int        n_sent = 0;
  int        n_seen = 0;
  int        op_cnt[4];
  int        dz_cnt = 0;
  longint    cycles = 0;
  int        burst_left = 0;
  bit        stall_on = 1;

  sign_magnitude_rational_alu_unit DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd60000000) begin
      $display("timeout at %0t", $time);
      $display("tb: errors");
      $finish;
    end
  end

  // receiver stall pattern: alternates between open stretches and random stalls
  always @(posedge clk) begin
    if (($urandom & 255) == 0) stall_on <= ~stall_on;
    out_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  // Euclid gcd with modulo, at 32 bits
  function automatic logic [31:0] gcd32(logic [31:0] x, logic [31:0] y);
    logic [31:0] t;
    while (y != 0) begin
      if (y > x) begin
        t = x; x = y; y = t;
      end else begin
        t = x % y; x = y; y = t;
      end
    end
    return x;
  endfunction

  function automatic logic [31:0] qdiv(logic [31:0] n, logic [31:0] d, ref logic dz);
    if (d == 0) begin
      dz = 1;
      return 0;
    end
    return n / d;
  endfunction

  function automatic rat_t reduce_rat(rat_t r, ref logic dz);
    logic [31:0] g;
    rat_t o;
    g = gcd32(r.num, r.den);
    o.sgn = r.sgn;
    o.num = qdiv(r.num, g, dz);
    o.den = qdiv(r.den, g, dz);
    return o;
  endfunction

  function automatic alu_res_t alu_predict(logic [1:0] op, rat_t a, rat_t b);
    alu_res_t r;
    rat_t p;
    logic dz;
    logic [31:0] l, ma, mb, pos, neg, an, bn;
    dz = 0;
    r = '{1'b0, 32'd0, 32'd0, 1'b0, 1'b0};
    case (op)
      OP_ADD: begin
        a = reduce_rat(a, dz);
        b = reduce_rat(b, dz);
        l = qdiv(a.den * b.den, gcd32(a.den, b.den), dz);
        ma = qdiv(l, a.den, dz);
        mb = qdiv(l, b.den, dz);
        an = a.num * ma;
        bn = b.num * mb;
        r.den = a.den * ma;
        if (a.sgn == b.sgn) begin
          r.sgn = a.sgn;
          r.num = an + bn;
        end else begin
          pos = a.sgn ? bn : an;
          neg = a.sgn ? an : bn;
          r.num = pos - neg;
          if (r.num > pos) begin
            r.num = -r.num;
            r.sgn = 1;
          end
        end
      end
      OP_MUL: begin
        a = reduce_rat(a, dz);
        b = reduce_rat(b, dz);
        p.sgn = a.sgn ^ b.sgn;
        p.num = a.num * b.num;
        p.den = a.den * b.den;
        p = reduce_rat(p, dz);
        r.sgn = p.sgn; r.num = p.num; r.den = p.den;
      end
      OP_SIMP: begin
        p = reduce_rat(a, dz);
        r.sgn = p.sgn; r.num = p.num; r.den = p.den;
      end
      default: begin
        logic [31:0] x, y;
        x = a.num * b.den;
        y = a.den * b.num;
        r.eq = (x == y);
      end
    endcase
    r.dz = dz;
    return r;
  endfunction

  // sends one request; bursts with random gaps
  task automatic send_req(logic [1:0] op, rat_t a, rat_t b);
    alu_res_t e;
    if (burst_left == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
    in_tvalid <= 1;
    in_tdata <= {4'd0, b.den, b.num, b.sgn, a.den, a.num, a.sgn, op};
    e = alu_predict(op, a, b);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_q.push_back(e);
    op_cnt[op]++;
    if (e.dz) dz_cnt++;
    n_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      alu_res_t e, g;
      g.sgn = out_tdata[0];
      g.num = out_tdata[32:1];
      g.den = out_tdata[64:33];
      g.eq = out_tdata[65];
      g.dz = out_tdata[66];
      n_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, g);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (g !== e) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, g);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 2);
      2: return $urandom_range(1, 1000);
      3: return $urandom_range(1, 1000) * $urandom_range(1, 60);
      4: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic rat_t rand_rat();
    rat_t r;
    r.sgn = 1'($urandom_range(0, 1));
    r.num = rand_word();
    r.den = rand_word();
    return r;
  endfunction

  task automatic wait_drained();
    in_tvalid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    rat_t z, one, mx, h, t;
    z = '{1'b0, 32'd0, 32'd0};
    one = '{1'b0, 32'd1, 32'd1};
    mx = '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    h = '{1'b0, 32'd1, 32'd2};
    t = '{1'b1, 32'd2, 32'd3};
    for (int op = 0; op < 4; op++) begin
      send_req(op[1:0], z, z);
      send_req(op[1:0], one, mx);
      send_req(op[1:0], h, t);
      send_req(op[1:0], t, h);
      send_req(op[1:0], mx, mx);
    end
    send_req(OP_ADD, '{1'b0, 32'd5, 32'd0}, h);
    send_req(OP_SIMP, '{1'b1, 32'd0, 32'd7}, z);
    send_req(OP_MUL, '{1'b0, 32'h8000_0000, 32'd3}, '{1'b1, 32'd6, 32'h8000_0001});
    send_req(OP_CMP, '{1'b0, 32'd2, 32'd4}, '{1'b1, 32'd3, 32'd6});
    send_req(OP_ADD, '{1'b0, 32'h7FFF_FFFF, 32'd1}, '{1'b0, 32'h7FFF_FFFF, 32'd1});
  endtask

  task automatic test_random(int n);
    rat_t a, b;
    for (int i = 0; i < n; i++) begin
      a = rand_rat();
      b = rand_rat();
      send_req(2'($urandom_range(0, 3)), a, b);
      if (i == n / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(1425);
    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d requests: add %0d, mul %0d, simplify %0d, compare %0d",
             n_sent, op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3]);
    $display("%0d results checked, %0d with a zero divisor", n_seen, dz_cnt);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
